// File: hdl/xml_entity_decoder_assert.svh
// Assertion macros for the XML entity decoder.
`ifndef XML_ENTITY_DECODER_ASSERT_SVH
`define XML_ENTITY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define XED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xed assertion failed: same-cycle implication");
`define XED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xed assertion failed: next-cycle implication");
`else
`define XED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define XED_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/xed_pkg.sv
// Types, codes and name tables of the XML entity decoder.
package xed_pkg;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_NAME  = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_SKIP  = 3'd3;

    localparam int         NUM_NAMES = 5;
    localparam logic [4:0] ALL_NAMES = 5'h1f;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] pos;
        logic [4:0] mask;
        logic [7:0] accum;
        logic       digit_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode: MODE_PLAIN, pos: 3'd0, mask: ALL_NAMES, accum: 8'd0, digit_seen: 1'b0
    };

    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
        logic       char_valid;
        logic       error;
        logic       done;
    } result_t;

    // Letter of name k at position pos (lt; gt; amp; apos; quot;).
    function automatic logic [7:0] name_letter(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            3'd0: begin
                case (pos)
                    3'd0: c = "l";
                    3'd1: c = "t";
                    3'd2: c = ";";
                    default: c = 8'h00;
                endcase
            end
            3'd1: begin
                case (pos)
                    3'd0: c = "g";
                    3'd1: c = "t";
                    3'd2: c = ";";
                    default: c = 8'h00;
                endcase
            end
            3'd2: begin
                case (pos)
                    3'd0: c = "a";
                    3'd1: c = "m";
                    3'd2: c = "p";
                    3'd3: c = ";";
                    default: c = 8'h00;
                endcase
            end
            3'd3: begin
                case (pos)
                    3'd0: c = "a";
                    3'd1: c = "p";
                    3'd2: c = "o";
                    3'd3: c = "s";
                    3'd4: c = ";";
                    default: c = 8'h00;
                endcase
            end
            3'd4: begin
                case (pos)
                    3'd0: c = "q";
                    3'd1: c = "u";
                    3'd2: c = "o";
                    3'd3: c = "t";
                    3'd4: c = ";";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] name_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0: n = 3'd3;
            3'd1: n = 3'd3;
            3'd2: n = 3'd4;
            3'd3: n = 3'd5;
            3'd4: n = 3'd5;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] name_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0: c = "<";
            3'd1: c = ">";
            3'd2: c = "&";
            3'd3: c = 8'h27;
            3'd4: c = 8'h22;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/xed_step.sv
// Combinational decode of one byte against the current decoder state.
module xed_step (
    input  logic [7:0]      in_byte,
    input  logic            last,
    input  xed_pkg::state_t cur,
    output xed_pkg::state_t nxt,
    output xed_pkg::result_t res
);

    logic [7:0] folded;
    logic [4:0] keep;
    logic       hit;
    logic [7:0] hit_char;
    logic [7:0] accum_next;
    logic       is_digit;
    logic       err;

    assign folded = (in_byte >= xed_pkg::CH_UPPER_A && in_byte <= xed_pkg::CH_UPPER_Z)
                    ? in_byte + xed_pkg::CASE_OFFSET : in_byte;
    assign is_digit = (in_byte >= xed_pkg::CH_ZERO) && (in_byte <= xed_pkg::CH_NINE);
    assign accum_next = {cur.accum[4:0], 3'b000} + {cur.accum[6:0], 1'b0}
                        + (in_byte - xed_pkg::CH_ZERO);

    // Name candidates are checked side by side.
    always_comb begin
        keep     = 5'd0;
        hit      = 1'b0;
        hit_char = 8'h00;
        for (int k = 0; k < xed_pkg::NUM_NAMES; k++) begin
            if (cur.mask[k] && cur.pos < xed_pkg::name_len(3'(k))
                && xed_pkg::name_letter(3'(k), cur.pos) == folded) begin
                if (cur.pos + 3'd1 == xed_pkg::name_len(3'(k))) begin
                    hit      = 1'b1;
                    hit_char = xed_pkg::name_char(3'(k));
                end else begin
                    keep[k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        nxt = cur;
        res = '0;
        err = 1'b0;
        case (cur.mode)
            xed_pkg::MODE_PLAIN: begin
                if (in_byte == 8'h00) begin
                    nxt.mode = xed_pkg::MODE_SKIP;
                end else if (in_byte == xed_pkg::CH_AMP) begin
                    nxt.mode = xed_pkg::MODE_NAME;
                    nxt.pos  = 3'd0;
                    nxt.mask = xed_pkg::ALL_NAMES;
                end else begin
                    res.emit       = 1'b1;
                    res.ch         = in_byte;
                    res.char_valid = 1'b1;
                end
            end
            xed_pkg::MODE_NAME: begin
                if (cur.pos == 3'd0 && in_byte == xed_pkg::CH_HASH) begin
                    nxt.mode       = xed_pkg::MODE_NUM;
                    nxt.accum      = 8'd0;
                    nxt.digit_seen = 1'b0;
                end else if (hit) begin
                    res.emit       = 1'b1;
                    res.ch         = hit_char;
                    res.char_valid = 1'b1;
                    nxt.mode       = xed_pkg::MODE_PLAIN;
                end else if (keep == 5'd0) begin
                    err = 1'b1;
                end else begin
                    nxt.mask = keep;
                    nxt.pos  = cur.pos + 3'd1;
                end
            end
            xed_pkg::MODE_NUM: begin
                if (is_digit) begin
                    nxt.accum      = accum_next;
                    nxt.digit_seen = 1'b1;
                end else if (in_byte == xed_pkg::CH_SEMI && cur.digit_seen) begin
                    res.emit       = 1'b1;
                    res.ch         = (cur.accum == 8'd0) ? xed_pkg::CH_SPACE : cur.accum;
                    res.char_valid = 1'b1;
                    nxt.mode       = xed_pkg::MODE_PLAIN;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (err) begin
            res.emit       = 1'b1;
            res.error      = 1'b1;
            res.ch         = 8'h00;
            res.char_valid = 1'b0;
            nxt.mode       = xed_pkg::MODE_SKIP;
        end

        if (last) begin
            if (nxt.mode == xed_pkg::MODE_NAME || nxt.mode == xed_pkg::MODE_NUM) begin
                res.error      = 1'b1;
                res.ch         = 8'h00;
                res.char_valid = 1'b0;
            end
            res.emit = 1'b1;
            res.done = 1'b1;
            nxt      = xed_pkg::STATE_RESET;
        end
    end

endmodule

// File: hdl/xml_entity_decoder.sv
// Top level of the XML entity decoder: input register, decode step, result register.
// Decodes XML character references in a byte stream at one byte per clock unless the
// result side stalls. A byte is taken into the input register, decoded against the
// running state and lands in the result register, which drives m_valid for its result.
// Each byte gives zero or one result; the byte marked last always gives one, with
// done_res set, and returns the decoder to plain text. Back-pressure on the result
// side stalls the input only when both registers are full.
module xml_entity_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_char_valid,
    output logic       m_error,
    output logic       m_done_res
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    xed_pkg::result_t out_reg;
    xed_pkg::state_t  state_reg;
    xed_pkg::state_t  state_next;
    xed_pkg::result_t step_res;
    logic             advance;

    xed_step u_step (
        .in_byte (in_byte_reg),
        .last    (in_last_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= xed_pkg::STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= step_res.emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_last;
        end
        if (advance && step_res.emit) begin
            out_reg <= step_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_char   = out_reg.ch;
    assign m_char_valid = out_reg.char_valid;
    assign m_error      = out_reg.error;
    assign m_done_res   = out_reg.done;

`include "xml_entity_decoder_assert.svh"

    `XED_ASSERT_IMP(a_valid_char_no_error, aclk, aresetn,
        m_valid && m_char_valid, !m_error && !m_done_res || !m_error)
    `XED_ASSERT_IMP(a_error_char_zero, aclk, aresetn,
        m_valid && m_error, m_out_char == 8'h00 && !m_char_valid)
    `XED_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `XED_ASSERT_NXT(a_last_resets_state, aclk, aresetn,
        advance && in_last_reg, state_reg == xed_pkg::STATE_RESET && m_valid && m_done_res)

endmodule
